/* rtl/core/ued_pkg.sv */
// ued_pkg: shared types, character constants and the hex digit decode
// for the escape sequence decoder. No dependencies.
package ued_pkg;

  // One result as it leaves the block
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;
    logic       trunc_error;
  } result_t;

  // Hex digit lookup result
  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  localparam logic [7:0] CharBackslash = 8'h5c;
  localparam logic [7:0] CharU         = 8'h75;
  localparam logic [2:0] HexLen        = 3'd4;

  // 0-9, a-f, A-F map to their value; anything else is not a digit
  function automatic hex_digit_t hex_digit(input logic [7:0] c);
    hex_digit_t d;
    d = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.valid = 1'b1;
      d.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.valid = 1'b1;
      d.value = 4'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.valid = 1'b1;
      d.value = 4'(c - 8'h41 + 8'd10);
    end
    return d;
  endfunction

endpackage

/* rtl/core/ued_in_if.sv */
// ued_in_if: character request channel (valid/ready plus payload).
// Depends on nothing.
interface ued_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

/* rtl/core/ued_out_if.sv */
// ued_out_if: decoded byte request channel (valid/ready plus payload).
// Depends on nothing.
interface ued_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       out_last;
  logic       trunc_error;

  modport source (output valid, output out_byte, output byte_valid, output out_last,
                  output trunc_error, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input out_last,
                  input trunc_error, output ready);
endinterface

/* rtl/core/unicode_escape_decoder.sv */
// unicode_escape_decoder: top level, decoder plus result queue.
// Depends on ued_pkg, ued_in_if, ued_out_if, ued_decoder, ued_res_queue.
//
// Usage: characters of an escaped string arrive on in_i, one request per
// character, in_last marking the final one. Backslash escapes are removed
// and \uXXXX becomes one or two bytes (high byte first when above 0xff).
// Each result leaves on out_o with out_byte, byte_valid, out_last and
// trunc_error; a string that ends inside \u gives one result with
// trunc_error set, and the consumer drops that string.
// Output: each result is registered in the result queue before it shows on out_o;
// the second byte of a two-byte result follows the first in the queue.
// Throughput: one character per cycle while out_o drains, set by the
// three-entry result queue; a two-byte result puts two entries in the queue but
// comes at most once per six characters, so in_i is not held off while
// out_o.ready stays high.
// Stall: when out_o.ready is low the queue fills and in_i.ready drops once
// fewer than two entries would be free; nothing is lost or repeated.
// Reset: clears the escape state and empties the queue; no clearing pass.
module unicode_escape_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  ued_in_if.sink    in_i,
  ued_out_if.source out_o
);

  logic             fire;
  logic             can_push;
  logic [1:0]       res_cnt;
  ued_pkg::result_t res0, res1, head;

  assign in_i.ready = can_push;
  assign fire       = in_i.valid & can_push;

  // Character decode and escape state
  ued_decoder u_decoder (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .char_i    (in_i.in_char),
    .last_i    (in_i.in_last),
    .res_cnt_o (res_cnt),
    .res0_o    (res0),
    .res1_o    (res1)
  );

  // Result registers
  ued_res_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (fire ? res_cnt : 2'd0),
    .res0_i     (res0),
    .res1_i     (res1),
    .pop_i      (out_o.ready),
    .can_push_o (can_push),
    .valid_o    (out_o.valid),
    .head_o     (head)
  );

  assign out_o.out_byte    = head.out_byte;
  assign out_o.byte_valid  = head.byte_valid;
  assign out_o.out_last    = head.out_last;
  assign out_o.trunc_error = head.trunc_error;

endmodule

/* rtl/core/ued_decoder.sv */
// ued_decoder: escape state registers and the per-character decode that
// yields zero, one or two results. Depends on ued_pkg.
module ued_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        char_i,
  input  logic              last_i,
  output logic [1:0]        res_cnt_o,
  output ued_pkg::result_t  res0_o,
  output ued_pkg::result_t  res1_o
);

  logic        esc_q, esc_d;
  logic [2:0]  left_q, left_d;
  logic [15:0] value_q, value_d;
  logic        stop_q, stop_d;

  ued_pkg::hex_digit_t dig;
  logic [15:0]         value_nx;
  logic [2:0]          left_nx;

  assign dig      = ued_pkg::hex_digit(char_i);
  assign value_nx = (!stop_q && dig.valid) ? {value_q[11:0], dig.value} : value_q;
  assign left_nx  = left_q - 3'd1;

  // Decode one character against the current escape state
  always_comb begin
    esc_d     = esc_q;
    left_d    = left_q;
    value_d   = value_q;
    stop_d    = stop_q;
    res_cnt_o = 2'd0;
    res0_o    = '0;
    res1_o    = '0;

    if (left_q != 3'd0) begin
      // inside a \u escape: consume the character
      value_d = value_nx;
      stop_d  = stop_q | ~dig.valid;
      left_d  = left_nx;
      if (left_nx == 3'd0) begin
        if (value_nx[15:8] != 8'd0) begin
          res0_o    = '{out_byte: value_nx[15:8], byte_valid: 1'b1,
                        out_last: 1'b0, trunc_error: 1'b0};
          res1_o    = '{out_byte: value_nx[7:0], byte_valid: 1'b1,
                        out_last: last_i, trunc_error: 1'b0};
          res_cnt_o = 2'd2;
        end else begin
          res0_o    = '{out_byte: value_nx[7:0], byte_valid: 1'b1,
                        out_last: last_i, trunc_error: 1'b0};
          res_cnt_o = 2'd1;
        end
        value_d = '0;
        stop_d  = 1'b0;
      end else if (last_i) begin
        res0_o    = '{out_byte: 8'd0, byte_valid: 1'b0, out_last: 1'b1, trunc_error: 1'b1};
        res_cnt_o = 2'd1;
      end
    end else if (char_i == ued_pkg::CharBackslash) begin
      esc_d = 1'b1;
      if (last_i) begin
        res0_o    = '{out_byte: 8'd0, byte_valid: 1'b0, out_last: 1'b1, trunc_error: 1'b0};
        res_cnt_o = 2'd1;
      end
    end else if (char_i == ued_pkg::CharU && esc_q) begin
      // start of \u: four characters follow
      esc_d   = 1'b0;
      left_d  = ued_pkg::HexLen;
      value_d = '0;
      stop_d  = 1'b0;
      if (last_i) begin
        res0_o    = '{out_byte: 8'd0, byte_valid: 1'b0, out_last: 1'b1, trunc_error: 1'b1};
        res_cnt_o = 2'd1;
      end
    end else begin
      esc_d     = 1'b0;
      res0_o    = '{out_byte: char_i, byte_valid: 1'b1, out_last: last_i, trunc_error: 1'b0};
      res_cnt_o = 2'd1;
    end

    // end of string returns everything to idle
    if (last_i) begin
      esc_d   = 1'b0;
      left_d  = '0;
      value_d = '0;
      stop_d  = 1'b0;
    end
  end

  // State update on each accepted character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q   <= 1'b0;
      left_q  <= '0;
      value_q <= '0;
      stop_q  <= 1'b0;
    end else if (fire_i) begin
      esc_q   <= esc_d;
      left_q  <= left_d;
      value_q <= value_d;
      stop_q  <= stop_d;
    end
  end

endmodule

/* rtl/core/ued_res_queue.sv */
// ued_res_queue: three-entry result register queue, takes up to two
// results per cycle while can_push_o is high and presents the oldest. Depends on ued_pkg.
module ued_res_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_cnt_i,
  input  ued_pkg::result_t  res0_i,
  input  ued_pkg::result_t  res1_i,
  input  logic              pop_i,
  output logic              can_push_o,
  output logic              valid_o,
  output ued_pkg::result_t  head_o
);

  localparam int Depth = 3;

  ued_pkg::result_t entry_q [Depth];
  ued_pkg::result_t entry_d [Depth];
  logic [1:0]       cnt_q, cnt_d, cnt_mid;
  logic             pop;

  assign valid_o    = (cnt_q != 2'd0);
  assign head_o     = entry_q[0];
  assign pop        = valid_o & pop_i;
  assign cnt_mid    = cnt_q - {1'b0, pop};
  assign can_push_o = (cnt_mid <= 2'd1);
  assign cnt_d      = cnt_mid + push_cnt_i;

  // Shift out the head, then append new results behind what remains
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (pop && i < Depth - 1) begin
        entry_d[i] = entry_q[i + 1];
      end else begin
        entry_d[i] = entry_q[i];
      end
      if (push_cnt_i != 2'd0 && 2'(i) == cnt_mid) begin
        entry_d[i] = res0_i;
      end
      if (push_cnt_i == 2'd2 && 2'(i) == 2'(cnt_mid + 2'd1)) begin
        entry_d[i] = res1_i;
      end
    end
  end

  // Payload entries
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      entry_q[i] <= entry_d[i];
    end
  end

  // Fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

/* tb/tb_unicode_escape_decoder.sv */
// tb_unicode_escape_decoder: self-checking bench for the escape sequence decoder.
// Depends on ued_pkg, ued_in_if, ued_out_if and unicode_escape_decoder.
// A behavioral decoder predicts each result; random idles are applied on both channels.
module tb_unicode_escape_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam int CharTarget = 450;

  logic clk_i;
  logic rst_ni;

  ued_in_if  chars_if ();
  ued_out_if bytes_if ();

  unicode_escape_decoder u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (chars_if),
    .out_o (bytes_if)
  );

  // Predicted decoder state
  logic        esc_armed;
  logic [2:0]  hex_left;
  logic [15:0] hex_acc;
  logic        hex_stop;

  ued_pkg::result_t decoded_q[$];
  ued_pkg::result_t want;
  ued_pkg::result_t got;
  int      mismatches;
  int      cycles;
  int      chars_sent;
  int      stall_left;
  bit      idle_on;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle count and timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("%0t: timeout, %0d results still expected", $time, decoded_q.size());
      $display("tb_unicode_escape_decoder failed");
      $finish;
    end
  end

  // Mostly short idles, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void add_result(input logic [7:0] b, input logic v, input logic l,
                                     input logic e);
    ued_pkg::result_t r;
    r.out_byte    = b;
    r.byte_valid  = v;
    r.out_last    = l;
    r.trunc_error = e;
    decoded_q.push_back(r);
  endfunction

  function automatic void clear_escape();
    esc_armed = 1'b0;
    hex_left  = '0;
    hex_acc   = '0;
    hex_stop  = 1'b0;
  endfunction

  // Behavioral decoder: one accepted character in, zero to two results queued
  function automatic void decode_char(input logic [7:0] c, input logic last);
    logic       is_hex;
    logic [3:0] nib;
    is_hex = 1'b1;
    nib    = '0;
    if (c >= "0" && c <= "9") nib = 4'(c - "0");
    else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 10);
    else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 10);
    else is_hex = 1'b0;

    if (hex_left != 0) begin
      // inside \uXXXX: every character is consumed
      if (!hex_stop && is_hex) hex_acc = {hex_acc[11:0], nib};
      else hex_stop = 1'b1;
      hex_left = hex_left - 3'd1;
      if (hex_left == 0) begin
        if (hex_acc > 16'h00ff) add_result(hex_acc[15:8], 1'b1, 1'b0, 1'b0);
        add_result(hex_acc[7:0], 1'b1, last, 1'b0);
        hex_acc  = '0;
        hex_stop = 1'b0;
      end else if (last) begin
        add_result(8'h00, 1'b0, 1'b1, 1'b1);
      end
    end else if (c == ued_pkg::CharBackslash) begin
      esc_armed = 1'b1;
      if (last) add_result(8'h00, 1'b0, 1'b1, 1'b0);
    end else if (c == ued_pkg::CharU && esc_armed) begin
      esc_armed = 1'b0;
      hex_left  = ued_pkg::HexLen;
      hex_acc   = '0;
      hex_stop  = 1'b0;
      if (last) add_result(8'h00, 1'b0, 1'b1, 1'b1);
    end else begin
      esc_armed = 1'b0;
      add_result(c, 1'b1, last, 1'b0);
    end
    if (last) clear_escape();
  endfunction

  // Send one character request and predict its results once accepted
  task automatic send_char(input logic [7:0] c, input logic last);
    chars_if.valid   <= 1'b1;
    chars_if.in_char <= c;
    chars_if.in_last <= last;
    do @(posedge clk_i); while (!chars_if.ready);
    decode_char(c, last);
    chars_sent++;
    if (idle_on && $urandom_range(0, 99) < 25) begin
      chars_if.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
  endtask

  // Whole string, in_last on its final character
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && bytes_if.valid && bytes_if.ready) begin
      got.out_byte    = bytes_if.out_byte;
      got.byte_valid  = bytes_if.byte_valid;
      got.out_last    = bytes_if.out_last;
      got.trunc_error = bytes_if.trunc_error;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        check_field("out_byte", want.out_byte, got.out_byte);
        check_field("byte_valid", want.byte_valid, got.byte_valid);
        check_field("out_last", want.out_last, got.out_last);
        check_field("trunc_error", want.trunc_error, got.trunc_error);
      end
    end
  end

  // Output backpressure: random stalls while idling is on
  initial begin
    bytes_if.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        bytes_if.ready <= 1'b0;
      end else begin
        bytes_if.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 99) < 15) stall_left = pick_gap();
      end
    end
  end

  // Zero byte, all-ones byte, a 'u' with no backslash before it
  task automatic test_plain_chars();
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(ued_pkg::CharU, 1'b1);
  endtask

  // Double backslash then a passed-through char; a trailing backslash gives no byte
  task automatic test_backslash();
    send_text("\\\\n");
    send_text("\\");
  endtask

  // Two-byte value in mixed case; digit run cut short by a non-hex char
  task automatic test_hex_escape();
    send_text("\\u20aC");
    send_text("\\u4g1\\");
  endtask

  // String ends on the 'u' or partway through the digits
  task automatic test_truncated_escape();
    send_text("\\u");
    send_text("\\u1");
  endtask

  // Random strings of plain chars, backslash pairs and \u escapes (digits sometimes non-hex), some cut off early
  task automatic test_random_strings();
    logic [7:0] text[$];
    int pieces;
    int kind;
    int v;
    int cut;
    while (chars_sent < CharTarget) begin
      text.delete();
      pieces = $urandom_range(1, 6);
      for (int p = 0; p < pieces; p++) begin
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
          text.push_back(8'($urandom_range(0, 255)));
        end else if (kind <= 5) begin
          text.push_back(ued_pkg::CharBackslash);
          text.push_back(8'($urandom_range(0, 255)));
        end else begin
          text.push_back(ued_pkg::CharBackslash);
          text.push_back(ued_pkg::CharU);
          repeat (4) begin
            v = $urandom_range(0, 15);
            if ($urandom_range(0, 99) < 12) text.push_back(8'($urandom_range(0, 255)));
            else if (v < 10) text.push_back(8'("0" + v));
            else if ($urandom_range(0, 1) == 1) text.push_back(8'("A" + v - 10));
            else text.push_back(8'("a" + v - 10));
          end
        end
      end
      if (text.size() > 1 && $urandom_range(0, 99) < 15) begin
        cut = $urandom_range(1, text.size() - 1);
        while (text.size() > cut) void'(text.pop_back());
      end
      idle_on = ($urandom_range(0, 3) != 0);
      foreach (text[i]) send_char(text[i], i == text.size() - 1);
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    chars_if.valid   <= 1'b0;
    chars_if.in_char <= '0;
    chars_if.in_last <= 1'b0;
    mismatches = 0;
    cycles     = 0;
    chars_sent = 0;
    idle_on    = 1'b1;
    clear_escape();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_plain_chars();
    test_backslash();
    test_hex_escape();
    test_truncated_escape();
    test_random_strings();
    chars_if.valid <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_unicode_escape_decoder passed");
    end else begin
      $display("tb_unicode_escape_decoder failed");
    end
    $finish;
  end

endmodule

/* unicode_escape_decoder.f */
rtl/core/ued_pkg.sv
rtl/core/ued_in_if.sv
rtl/core/ued_out_if.sv
rtl/core/ued_decoder.sv
rtl/core/ued_res_queue.sv
rtl/core/unicode_escape_decoder.sv
tb/tb_unicode_escape_decoder.sv
